// ===== hw/rtl/mdms_pkg.sv =====
// mdms_pkg: shared types and codes of the motor drive mode sequencer
`default_nettype none

package mdms_pkg;

    localparam int unsigned OFFSET_CAL_LEN = 2048;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned THR_W      = 15;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_CAL   = 3'd1,
        MODE_ALIGN = 3'd2,
        MODE_RUN   = 3'd3,
        MODE_OPEN  = 3'd4,
        MODE_FAULT = 3'd5
    } t_mode;

    // the two spare codes are ignored like none
    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_ALIGN_ONLY = 3'd1,
        OP_RUN        = 3'd2,
        OP_STOP       = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_OPEN_LOOP  = 3'd5,
        OP_SPARE6     = 3'd6,
        OP_SPARE7     = 3'd7
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROT_EN   = 2'd0,
        CFG_SHORT_THR = 2'd1,
        CFG_ALIGN_ID  = 2'd2,
        CFG_RUN_ID    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]         opcode;
        logic               raise_fault;
        logic [15:0]        fault_code;
        logic               align_done;
        logic signed [15:0] healthy_speed;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]         mode;
        logic               mode_entered;
        logic               gate_enable;
        logic               force_safe_pwm;
        logic               clear_driver_faults;
        logic               start_offset_cal;
        logic               load_current_ref;
        logic signed [15:0] d_current_ref;
        logic               active_short;
        logic               prot_clear;
        logic               prot_latch;
        logic [15:0]        latched_code;
    } t_out_beat;

    typedef struct packed {
        logic               protection_enable;
        logic [THR_W-1:0]   short_speed_threshold;
        logic signed [15:0] align_d_current;
        logic signed [15:0] run_d_current;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hw/rtl/mdms_cfg.sv =====
// mdms_cfg: configuration register file
`default_nettype none

module mdms_cfg
    import mdms_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.protection_enable     <= 1'b1;
            r_cfg.short_speed_threshold <= THR_W'(1000);
            r_cfg.align_d_current       <= 16'sd0;
            r_cfg.run_d_current         <= 16'sd0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PROT_EN:   r_cfg.protection_enable     <= i_cfg_data[0];
                CFG_SHORT_THR: r_cfg.short_speed_threshold <= i_cfg_data[THR_W-1:0];
                CFG_ALIGN_ID:  r_cfg.align_d_current       <= $signed(i_cfg_data);
                CFG_RUN_ID:    r_cfg.run_d_current         <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hw/rtl/mdms_in_stage.sv =====
// mdms_in_stage: input register holding one tick beat until the sequencer takes it
`default_nettype none

module mdms_in_stage
    import mdms_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_beat i_in_data,
    input  wire logic     i_adv,
    output logic          o_vld,
    output t_in_beat      o_beat
);

    logic     r_vld;
    t_in_beat r_beat;
    logic     take;

    // stall only when a held beat cannot move on this cycle
    assign o_in_stall = r_vld && !i_adv;
    assign take       = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (i_adv) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_beat <= i_in_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_beat = r_beat;

endmodule

`default_nettype wire

// ===== hw/rtl/mdms_seq.sv =====
// mdms_seq: mode state registers and the per-tick transition logic
`default_nettype none

module mdms_seq
    import mdms_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_adv,
    input  wire t_in_beat i_beat,
    input  wire t_cfg     i_cfg,
    output t_out_beat     o_res
);

    t_mode r_mode,  n_mode;
    t_mode r_pend,  n_pend;
    logic  r_aof,   n_aof;
    logic  r_fw,    n_fw;
    logic  r_ra,    n_ra;
    logic  r_gate,  n_gate;
    logic  r_short, n_short;

    logic        go;
    t_mode       go_to;
    logic        s_clear;
    logic        p_safe, p_clrdrv, p_cal, p_load;
    logic signed [15:0] p_dref;
    logic [16:0] spd_ext;
    logic [16:0] spd_abs;
    logic        fast;

    // |speed| on 17 bits so that the most negative value stays exact
    assign spd_ext = {i_beat.healthy_speed[15], i_beat.healthy_speed};
    assign spd_abs = spd_ext[16] ? (~spd_ext + 17'd1) : spd_ext;
    assign fast    = spd_abs > {2'b00, i_cfg.short_speed_threshold};

    always_comb begin
        n_mode   = r_mode;
        n_pend   = r_pend;
        n_aof    = r_aof;
        n_fw     = r_fw | i_beat.raise_fault;
        n_ra     = r_ra;
        n_gate   = r_gate;
        n_short  = r_short;
        go       = 1'b0;
        go_to    = MODE_IDLE;
        s_clear  = 1'b0;
        p_safe   = 1'b0;
        p_clrdrv = 1'b0;
        p_cal    = 1'b0;
        p_load   = 1'b0;
        p_dref   = 16'sd0;

        unique case (t_opcode'(i_beat.opcode))
            OP_ALIGN_ONLY: begin
                n_aof  = 1'b1;
                n_pend = MODE_ALIGN;
            end
            OP_RUN: begin
                n_aof  = 1'b0;
                n_pend = MODE_RUN;
            end
            OP_STOP: n_pend = MODE_IDLE;
            OP_CLEAR: begin
                if (r_mode == MODE_FAULT) begin
                    s_clear = 1'b1;
                    n_pend  = MODE_IDLE;
                end
            end
            OP_OPEN_LOOP: n_pend = MODE_OPEN;
            default: ;
        endcase

        // outside fault mode, a waiting fault wins over every other transition
        if (n_fw && r_mode != MODE_FAULT) begin
            go    = 1'b1;
            go_to = MODE_FAULT;
            n_fw  = 1'b0;
        end else begin
            unique case (r_mode)
                MODE_IDLE: begin
                    if (n_pend == MODE_ALIGN || n_pend == MODE_RUN) begin
                        go    = 1'b1;
                        go_to = MODE_CAL;
                    end else if (n_pend == MODE_OPEN && !i_cfg.protection_enable) begin
                        go    = 1'b1;
                        go_to = MODE_OPEN;
                    end else if (n_pend == MODE_OPEN) begin
                        n_pend = MODE_IDLE;
                    end
                end
                MODE_CAL: begin
                    go    = 1'b1;
                    go_to = (n_aof || !r_ra) ? MODE_ALIGN : MODE_RUN;
                end
                MODE_ALIGN: begin
                    if (i_beat.align_done) begin
                        n_ra = 1'b1;
                        go   = 1'b1;
                        if (n_aof) begin
                            n_pend = MODE_IDLE;
                            go_to  = MODE_IDLE;
                        end else begin
                            go_to  = MODE_RUN;
                        end
                    end
                end
                default: begin
                    if (n_pend == MODE_IDLE) begin
                        go    = 1'b1;
                        go_to = MODE_IDLE;
                    end
                end
            endcase
        end

        // entry actions
        if (go) begin
            n_mode = go_to;
            unique case (go_to)
                MODE_IDLE: begin
                    n_gate = 1'b0;
                    p_safe = 1'b1;
                end
                MODE_CAL: begin
                    n_gate   = 1'b1;
                    p_clrdrv = 1'b1;
                    p_safe   = 1'b1;
                    p_cal    = 1'b1;
                end
                MODE_ALIGN: begin
                    n_gate = 1'b1;
                    p_load = 1'b1;
                    p_dref = i_cfg.align_d_current;
                end
                MODE_RUN: begin
                    n_gate = 1'b1;
                    p_load = 1'b1;
                    p_dref = i_cfg.run_d_current;
                end
                MODE_OPEN: begin
                    n_gate   = 1'b1;
                    p_clrdrv = 1'b1;
                end
                default: begin
                    n_short = fast;
                    n_gate  = fast;
                    p_safe  = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pend  <= MODE_IDLE;
            r_aof   <= 1'b0;
            r_fw    <= 1'b0;
            r_ra    <= 1'b0;
            r_gate  <= 1'b0;
            r_short <= 1'b0;
        end else if (i_adv) begin
            r_mode  <= n_mode;
            r_pend  <= n_pend;
            r_aof   <= n_aof;
            r_fw    <= n_fw;
            r_ra    <= n_ra;
            r_gate  <= n_gate;
            r_short <= n_short;
        end
    end

    always_comb begin
        o_res.mode                = n_mode;
        o_res.mode_entered        = go;
        o_res.gate_enable         = n_gate;
        o_res.force_safe_pwm      = p_safe;
        o_res.clear_driver_faults = p_clrdrv;
        o_res.start_offset_cal    = p_cal;
        o_res.load_current_ref    = p_load;
        o_res.d_current_ref       = p_dref;
        o_res.active_short        = (n_mode == MODE_FAULT) && n_short;
        o_res.prot_clear          = s_clear;
        o_res.prot_latch          = i_beat.raise_fault;
        o_res.latched_code        = i_beat.raise_fault ? i_beat.fault_code : 16'd0;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mdms_out_stage.sv =====
// mdms_out_stage: result register toward the output channel
`default_nettype none

module mdms_out_stage
    import mdms_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_src_vld,
    input  wire t_out_beat i_res,
    output logic           o_adv,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_data
);

    logic      r_vld;
    t_out_beat r_res;

    // the register is free when empty or when its beat leaves this cycle
    assign o_adv = i_src_vld && (!r_vld || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_adv) begin
            r_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_vld;
    assign o_out_data  = r_res;

endmodule

`default_nettype wire

// ===== hw/rtl/motor_drive_mode_sequencer.sv =====
// motor_drive_mode_sequencer: top level of the motor drive mode sequencer
//
//   channel | direction | valid       | stall       | payload
//   --------+-----------+-------------+-------------+------------
//   in      | input     | i_in_valid  | o_in_stall  | i_in_data
//   out     | output    | o_out_valid | i_out_stall | o_out_data
//   cfg     | input     | i_cfg_we    | -           | i_cfg_idx, i_cfg_data
//
// one tick beat per cycle while the output is not stalled; each beat is held in the
// input register and its result in the result register until the output takes it
// the mode update runs in one pass of logic between the two registers
// reset (synchronous, active low) puts the block in idle with all sequencer flags clear
// a stall on the output holds the result register and backs up into the input
`default_nettype none

module motor_drive_mode_sequencer
    import mdms_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_beat              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_beat                  o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_in_beat  in_beat;
    t_out_beat res;
    logic      in_vld;
    logic      adv;

    mdms_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mdms_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_adv      (adv),
        .o_vld      (in_vld),
        .o_beat     (in_beat)
    );

    mdms_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_beat  (in_beat),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    mdms_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_src_vld   (in_vld),
        .i_res       (res),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/mdms_checker.sv =====
// mdms_checker: port-level assertions for the mode sequencer, bound to the top level
`default_nettype none

module mdms_checker
    import mdms_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_beat o_out_data
);

    // a stalled result beat stays and keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed under stall");

    // no result right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // active short is only shown in fault mode
    a_short_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.active_short |-> o_out_data.mode == MODE_FAULT)
        else $error("active short outside fault mode");

    // entry pulses only come with a mode entry
    a_pulse_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.force_safe_pwm || o_out_data.load_current_ref ||
                        o_out_data.clear_driver_faults || o_out_data.start_offset_cal)
        |-> o_out_data.mode_entered)
        else $error("entry pulse without mode entry");

    // fault code is only passed on with the latch pulse
    a_code_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.prot_latch |-> o_out_data.latched_code == 16'd0)
        else $error("fault code without latch pulse");

endmodule

bind motor_drive_mode_sequencer mdms_checker u_mdms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
